FILE: rtl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants for the site dedup unit
// Command codes, reset values and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tsd_pkg;

  // command field width and codes
  localparam int CMD_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e_t;

  // read index field width
  localparam int IDX_BITS = 6;

  // tolerance register
  localparam int            TOL_BITS  = 16;
  localparam logic [15:0]   TOL_RESET = 16'd5;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted input item
    logic step;    // issue one scan read and advance the pointer
    logic rd_idx;  // issue a read at the requested index
    logic commit;  // apply the result and load the output register
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic in_is_add;   // incoming item is an add
    logic in_is_read;  // incoming item is a read
    logic scan_more;   // pointer is still below one of the fills
    logic out_free;    // output register can take a new result
  } sts_t;

endpackage

FILE: rtl/tsd_ctrl.sv
// ----------------------------------------------------------------------------
// tsd_ctrl: sequencer for the site dedup unit
// Walks each item through capture, list scan or index read, and commit.
// ----------------------------------------------------------------------------
module tsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tsd_pkg::sts_t sts,
  output tsd_pkg::ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDMEM,
    ST_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode
  always_comb begin
    ctl.load   = accept;
    ctl.step   = (state_r == ST_SCAN) && sts.scan_more;
    ctl.rd_idx = (state_r == ST_RDMEM);
    ctl.commit = (state_r == ST_COMMIT) && sts.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (sts.in_is_add) state_nxt = ST_SCAN;
          else if (sts.in_is_read)    state_nxt = ST_RDMEM;
          else                        state_nxt = ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (!sts.scan_more) state_nxt = ST_COMMIT;
      end
      ST_RDMEM: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/tsd_datapath.sv
// ----------------------------------------------------------------------------
// tsd_datapath: site lists, scan compare and result register
// Two site memories scanned one entry a cycle in parallel, fill counters,
// the tolerance register and the output register.
// ----------------------------------------------------------------------------
module tsd_datapath #(
  parameter int MAX_SITES = 64,
  parameter int POS_BITS  = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsd_pkg::ctl_t                 ctl,
  output tsd_pkg::sts_t                 sts,
  // input item fields
  input  logic [tsd_pkg::CMD_BITS-1:0]  in_cmd,
  input  logic [POS_BITS-1:0]           in_start_pos,
  input  logic [POS_BITS-1:0]           in_end_pos,
  input  logic [tsd_pkg::IDX_BITS-1:0]  in_read_index,
  // configuration write
  input  logic                          cfg_valid,
  input  logic [tsd_pkg::TOL_BITS-1:0]  cfg_data,
  // result channel
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          start_added,
  output logic                          end_added,
  output logic                          start_dropped,
  output logic                          end_dropped,
  output logic [$clog2(MAX_SITES+1)-1:0] start_fill,
  output logic [$clog2(MAX_SITES+1)-1:0] end_fill,
  output logic [POS_BITS-1:0]           start_site_out,
  output logic [POS_BITS-1:0]           end_site_out,
  output logic                          start_site_valid,
  output logic                          end_site_valid
);

  localparam int AW = $clog2(MAX_SITES);
  localparam int CW = $clog2(MAX_SITES + 1);
  localparam int IW = (AW > tsd_pkg::IDX_BITS) ? AW : tsd_pkg::IDX_BITS;
  localparam int XW = (CW > tsd_pkg::IDX_BITS) ? CW : tsd_pkg::IDX_BITS;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SITES);

  // site memories
  logic [POS_BITS-1:0] s_mem [MAX_SITES];
  logic [POS_BITS-1:0] e_mem [MAX_SITES];

  // captured item
  logic [tsd_pkg::CMD_BITS-1:0] cmd_r;
  logic [POS_BITS-1:0]          spos_r;
  logic [POS_BITS-1:0]          epos_r;
  logic [tsd_pkg::IDX_BITS-1:0] idx_r;

  logic [tsd_pkg::TOL_BITS-1:0] tol_r;
  logic [CW-1:0]                scount_r;
  logic [CW-1:0]                ecount_r;
  logic [CW-1:0]                scount_nxt;
  logic [CW-1:0]                ecount_nxt;
  logic [CW-1:0]                ptr_r;
  logic                         s_rv_r;
  logic                         e_rv_r;
  logic                         snear_r;
  logic                         enear_r;
  logic [POS_BITS-1:0]          s_rd_r;
  logic [POS_BITS-1:0]          e_rd_r;
  logic                         out_valid_r;

  logic                is_add;
  logic                is_read;
  logic                is_clear;
  logic                s_ptr_in;
  logic                e_ptr_in;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [IW-1:0]       idx_w;
  logic [POS_BITS-1:0] tol_ext;
  logic                s_hit;
  logic                e_hit;
  logic                s_full;
  logic                e_full;
  logic                s_add;
  logic                e_add;
  logic                s_drop;
  logic                e_drop;
  logic                s_val;
  logic                e_val;

  function automatic logic [POS_BITS-1:0] abs_diff(input logic [POS_BITS-1:0] a,
                                                   input logic [POS_BITS-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // command decode of the captured item
  assign is_add   = (cmd_r == tsd_pkg::CMD_ADD);
  assign is_read  = (cmd_r == tsd_pkg::CMD_READ);
  assign is_clear = (cmd_r == tsd_pkg::CMD_CLEAR);

  // scan pointer against both fills
  assign s_ptr_in = (ptr_r < scount_r);
  assign e_ptr_in = (ptr_r < ecount_r);

  // status back to the controller
  always_comb begin
    sts.in_is_add  = (in_cmd == tsd_pkg::CMD_ADD);
    sts.in_is_read = (in_cmd == tsd_pkg::CMD_READ);
    sts.scan_more  = s_ptr_in || e_ptr_in;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // shared read port address
  assign idx_w   = IW'(idx_r);
  assign rd_en   = ctl.step || ctl.rd_idx;
  assign rd_addr = ctl.rd_idx ? idx_w[AW-1:0] : ptr_r[AW-1:0];

  // tolerance compare on the registered read data
  assign tol_ext = POS_BITS'(tol_r);
  assign s_hit   = s_rv_r && (abs_diff(s_rd_r, spos_r) <= tol_ext);
  assign e_hit   = e_rv_r && (abs_diff(e_rd_r, epos_r) <= tol_ext);

  // outcome of the item at commit
  assign s_full = (scount_r == MAX_C);
  assign e_full = (ecount_r == MAX_C);
  assign s_add  = is_add && !snear_r && !s_full;
  assign e_add  = is_add && !enear_r && !e_full;
  assign s_drop = is_add && !snear_r && s_full;
  assign e_drop = is_add && !enear_r && e_full;
  assign s_val  = is_read && (XW'(idx_r) < XW'(scount_r));
  assign e_val  = is_read && (XW'(idx_r) < XW'(ecount_r));

  always_comb begin
    scount_nxt = scount_r;
    ecount_nxt = ecount_r;
    priority if (is_clear) begin
      scount_nxt = '0;
      ecount_nxt = '0;
    end else begin
      if (s_add) scount_nxt = scount_r + CW'(1);
      if (e_add) ecount_nxt = ecount_r + CW'(1);
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (ctl.commit && s_add) s_mem[scount_r[AW-1:0]] <= spos_r;
    if (ctl.commit && e_add) e_mem[ecount_r[AW-1:0]] <= epos_r;
    if (rd_en) begin
      s_rd_r <= s_mem[rd_addr];
      e_rd_r <= e_mem[rd_addr];
    end
  end

  // item capture, scan pointer and near flags
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      spos_r <= in_start_pos;
      epos_r <= in_end_pos;
      idx_r  <= in_read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      s_rv_r  <= 1'b0;
      e_rv_r  <= 1'b0;
      snear_r <= 1'b0;
      enear_r <= 1'b0;
    end else begin
      s_rv_r <= ctl.step && s_ptr_in;
      e_rv_r <= ctl.step && e_ptr_in;
      if (ctl.load) begin
        ptr_r   <= '0;
        snear_r <= 1'b0;
        enear_r <= 1'b0;
      end else begin
        if (ctl.step) ptr_r <= ptr_r + CW'(1);
        if (s_hit) snear_r <= 1'b1;
        if (e_hit) enear_r <= 1'b1;
      end
    end
  end

  // tolerance register and fill counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= tsd_pkg::TOL_RESET;
      scount_r <= '0;
      ecount_r <= '0;
    end else begin
      if (cfg_valid) tol_r <= cfg_data;
      if (ctl.commit) begin
        scount_r <= scount_nxt;
        ecount_r <= ecount_nxt;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      start_added      <= s_add;
      end_added        <= e_add;
      start_dropped    <= s_drop;
      end_dropped      <= e_drop;
      start_fill       <= scount_nxt;
      end_fill         <= ecount_nxt;
      start_site_out   <= s_val ? s_rd_r : '0;
      end_site_out     <= e_val ? e_rd_r : '0;
      start_site_valid <= s_val;
      end_site_valid   <= e_val;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/tolerant_site_dedup_unit.sv
// Flow: an add scans both site lists together, one scan read per cycle through each site memory
// port, over as many entries as the larger fill (up to 64 with MAX_SITES = 64); a read takes
// one index read; clear and unused commands go straight to commit. One item in work at a time:
// a new input item is taken only after the last result has been loaded into the output register.
// Reset: synchronous active-low rst_n empties both lists and sets tolerance to 5;
// site memories need no clearing pass.
// ----------------------------------------------------------------------------
// tolerant_site_dedup_unit: tolerant start/end site deduplicator
// Keeps two site lists and appends a position only when no stored site
// lies within the tolerance; also reads back and clears the lists.
// ----------------------------------------------------------------------------
module tolerant_site_dedup_unit #(
  parameter int MAX_SITES = 64,
  parameter int POS_BITS  = 31
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cmd, start_pos, end_pos, read_index
  input  logic [((2*POS_BITS + tsd_pkg::CMD_BITS + tsd_pkg::IDX_BITS + 7) / 8) * 8 - 1:0]
                                              in_tdata,
  // configuration write (tolerance)
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsd_pkg::TOL_BITS-1:0]        cfg_data,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // start_added, end_added, start_dropped, end_dropped, start_fill, end_fill,
  // start_site_out, end_site_out, start_site_valid, end_site_valid
  output logic [((2*POS_BITS + 2*$clog2(MAX_SITES+1) + 6 + 7) / 8) * 8 - 1:0]
                                              out_tdata
);

  localparam int CW    = $clog2(MAX_SITES + 1);
  localparam int IN_W  = ((2*POS_BITS + tsd_pkg::CMD_BITS + tsd_pkg::IDX_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2*POS_BITS + 2*CW + 6 + 7) / 8) * 8;
  localparam int SP_LO = tsd_pkg::CMD_BITS;
  localparam int EP_LO = SP_LO + POS_BITS;
  localparam int IX_LO = EP_LO + POS_BITS;

  tsd_pkg::ctl_t ctl;
  tsd_pkg::sts_t sts;

  logic                start_added;
  logic                end_added;
  logic                start_dropped;
  logic                end_dropped;
  logic [CW-1:0]       start_fill;
  logic [CW-1:0]       end_fill;
  logic [POS_BITS-1:0] start_site_out;
  logic [POS_BITS-1:0] end_site_out;
  logic                start_site_valid;
  logic                end_site_valid;

  // tolerance must be written only while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;

  tsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tsd_datapath #(
    .MAX_SITES (MAX_SITES),
    .POS_BITS  (POS_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_tdata[tsd_pkg::CMD_BITS-1:0]),
    .in_start_pos     (in_tdata[SP_LO +: POS_BITS]),
    .in_end_pos       (in_tdata[EP_LO +: POS_BITS]),
    .in_read_index    (in_tdata[IX_LO +: tsd_pkg::IDX_BITS]),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .start_added      (start_added),
    .end_added        (end_added),
    .start_dropped    (start_dropped),
    .end_dropped      (end_dropped),
    .start_fill       (start_fill),
    .end_fill         (end_fill),
    .start_site_out   (start_site_out),
    .end_site_out     (end_site_out),
    .start_site_valid (start_site_valid),
    .end_site_valid   (end_site_valid)
  );

  // result packing, start_added in the lowest bit, then the fields in port-list order upward
  assign out_tdata = OUT_W'({end_site_valid, start_site_valid, end_site_out, start_site_out,
                             end_fill, start_fill, end_dropped, start_dropped,
                             end_added, start_added});

endmodule

FILE: rtl/tsd_checker.sv
// ----------------------------------------------------------------------------
// tsd_checker: port-level checks for the site dedup unit
// Watches the input and result stream ports; bound to the top level.
// ----------------------------------------------------------------------------
module tsd_checker #(
  parameter int IN_W  = 72,
  parameter int OUT_W = 88
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic in_xfer;
  logic slow_cmd;

  assign in_xfer  = in_tvalid && in_tready;
  assign slow_cmd = (in_tdata[tsd_pkg::CMD_BITS-1:0] == tsd_pkg::CMD_ADD) ||
                    (in_tdata[tsd_pkg::CMD_BITS-1:0] == tsd_pkg::CMD_READ);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // one item at a time: busy right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while an item is in work");

  // add and read need a memory access before commit
  a_slow_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && slow_cmd |=> !in_tready ##1 !in_tready)
    else $error("add or read finished too early");

endmodule

bind tolerant_site_dedup_unit tsd_checker #(
  .IN_W  (IN_W),
  .OUT_W (OUT_W)
) u_tsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/tb_tolerant_site_dedup_unit.sv
// ----------------------------------------------------------------------------
// tb_tolerant_site_dedup_unit: self-checking bench for the site dedup unit
// Streams add, read, clear and unused commands through the unit under several
// tolerance settings. A predictor of the two site lists computes each result
// when the command transfer happens. The monitor then compares every result
// transfer with it field by field. Sender bursts and receiver stalls are
// random, with a long receiver hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb_tolerant_site_dedup_unit;

  localparam int CMD_W      = tsd_pkg::CMD_BITS;
  localparam int IDX_W      = tsd_pkg::IDX_BITS;
  localparam int TOL_W      = tsd_pkg::TOL_BITS;
  localparam int POS_W      = 31;
  localparam int FILL_W     = 7;
  localparam int LIST_DEPTH = 64;
  localparam int IN_W       = ((2*POS_W + CMD_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_W      = ((2*POS_W + 2*FILL_W + 6 + 7) / 8) * 8;
  localparam logic [POS_W-1:0] POS_MAX    = '1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int START_LIST   = 0;
  localparam int END_LIST     = 1;
  localparam int CYCLE_LIMIT  = 900000;
  localparam int PHASE_ITEMS  = 140;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic [IDX_W-1:0] idx;
  } site_cmd_t;

  typedef struct {
    logic              s_add;
    logic              e_add;
    logic              s_drop;
    logic              e_drop;
    logic [FILL_W-1:0] s_fill;
    logic [FILL_W-1:0] e_fill;
    logic [POS_W-1:0]  s_site;
    logic [POS_W-1:0]  e_site;
    logic              s_val;
    logic              e_val;
  } site_result_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // predictor state: both site lists, their fills and the tolerance
  logic [POS_W-1:0] site_mem [2][LIST_DEPTH];
  int               site_cnt [2] = '{0, 0};
  logic [TOL_W-1:0] tol_reg = tsd_pkg::TOL_RESET;

  site_cmd_t    site_cmds[$];        // commands waiting to be sent
  site_result_t pending_results[$];  // predicted results not yet seen
  logic [POS_W-1:0] pos_pool[$];     // recent positions, seeds for near hits
  site_cmd_t    cur_cmd;

  int fails = 0;
  int sent = 0;
  int seen = 0;
  int tol_writes = 0;
  int start_adds = 0, end_adds = 0, start_drops = 0, end_drops = 0, read_hits = 0;
  int cycle_count = 0;

  tolerant_site_dedup_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // append pos to one list unless a stored site lies within tolerance; a full list drops it
  function automatic void offer_site(input int lst, input logic [POS_W-1:0] pos,
                                     output logic added, output logic dropped);
    logic        near_hit = 1'b0;
    logic [31:0] d;
    added = 1'b0;
    dropped = 1'b0;
    for (int i = 0; i < site_cnt[lst]; i++) begin
      d = (site_mem[lst][i] > pos) ? site_mem[lst][i] - pos : pos - site_mem[lst][i];
      if (d <= {16'd0, tol_reg}) near_hit = 1'b1;
    end
    if (!near_hit) begin
      if (site_cnt[lst] >= LIST_DEPTH) begin
        dropped = 1'b1;
      end else begin
        site_mem[lst][site_cnt[lst]] = pos;
        site_cnt[lst]++;
        added = 1'b1;
      end
    end
  endfunction

  // expected result of one command, updating the predicted lists
  function automatic site_result_t predict_sites(input site_cmd_t c);
    site_result_t r = '{default: '0};
    case (c.cmd)
      tsd_pkg::CMD_ADD: begin
        offer_site(START_LIST, c.start_pos, r.s_add, r.s_drop);
        offer_site(END_LIST, c.end_pos, r.e_add, r.e_drop);
      end
      tsd_pkg::CMD_READ: begin
        if (c.idx < site_cnt[START_LIST]) begin
          r.s_site = site_mem[START_LIST][c.idx];
          r.s_val = 1'b1;
        end
        if (c.idx < site_cnt[END_LIST]) begin
          r.e_site = site_mem[END_LIST][c.idx];
          r.e_val = 1'b1;
        end
      end
      tsd_pkg::CMD_CLEAR: begin
        site_cnt[START_LIST] = 0;
        site_cnt[END_LIST] = 0;
      end
      default: ;
    endcase
    r.s_fill = FILL_W'(site_cnt[START_LIST]);
    r.e_fill = FILL_W'(site_cnt[END_LIST]);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  function automatic void push_cmd(input logic [CMD_W-1:0] cmd,
                                   input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
                                   input logic [IDX_W-1:0] idx);
    site_cmd_t c;
    c.cmd = cmd;
    c.start_pos = s;
    c.end_pos = e;
    c.idx = idx;
    site_cmds.insert(site_cmds.size(), c);
  endfunction

  // position generator: near earlier positions, at the range ends, or anywhere
  function automatic logic [POS_W-1:0] pick_pos(input int unsigned tol_now);
    logic [63:0]      off;
    logic [63:0]      p;
    logic [POS_W-1:0] base;
    int unsigned      r = $urandom_range(0, 99);
    if (r < 45 && pos_pool.size() > 0) begin
      base = pos_pool[$urandom_range(0, pos_pool.size() - 1)];
      if ($urandom_range(0, 2) == 0) off = tol_now + $urandom_range(0, 1);
      else off = $urandom_range(0, tol_now + 2);
      if ($urandom_range(0, 1)) p = (base > off) ? base - off : 64'd0;
      else p = base + off;
      if (p > POS_MAX) p = POS_MAX;
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0: p = 0;
        1: p = POS_MAX;
        2: p = $urandom_range(0, tol_now + 2);
        default: p = POS_MAX - $urandom_range(0, tol_now + 2);
      endcase
    end else begin
      p = $urandom() & POS_MAX;
    end
    pos_pool.insert(pos_pool.size(), p[POS_W-1:0]);
    if (pos_pool.size() > LIST_DEPTH) void'(pos_pool.pop_front());
    return p[POS_W-1:0];
  endfunction

  // one phase of random commands; well-formed adds dominate
  function automatic void queue_phase(input int n, input int clear_pct,
                                      input int unsigned tol_now);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct)
        push_cmd(tsd_pkg::CMD_CLEAR, POS_W'($urandom()), POS_W'($urandom()),
                 IDX_W'($urandom()));
      else if (r < clear_pct + 2)
        push_cmd(CMD_UNUSED, POS_W'($urandom()), POS_W'($urandom()),
                 IDX_W'($urandom()));
      else if (r < clear_pct + 17)
        push_cmd(tsd_pkg::CMD_READ, POS_W'($urandom()), POS_W'($urandom()),
                 IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63)));
      else
        push_cmd(tsd_pkg::CMD_ADD, pick_pos(tol_now), pick_pos(tol_now),
                 IDX_W'($urandom()));
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (site_cmds.size() != 0 || in_tvalid || pending_results.size() != 0);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_reg = v;
    tol_writes++;
  endtask

  // command driver: bursts of random length with random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    logic offer;
    offer = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.insert(pending_results.size(), predict_sites(cur_cmd));
        sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (site_cmds.size() > 0) begin
          cur_cmd = site_cmds.pop_front();
          offer = 1'b1;
          in_tdata <= {2'b00, cur_cmd.idx, cur_cmd.end_pos, cur_cmd.start_pos, cur_cmd.cmd};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_tvalid <= offer;
      end
    end
  end

  // result monitor and receiver stall pattern
  int hold_left = 0;
  int long_holds = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    site_result_t want;
    logic         rdy;
    if (out_tvalid && out_tready) begin
      seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no command awaiting it");
        fails++;
      end else begin
        want = pending_results.pop_front();
        // fields from the lowest bit up
        check_field("start_added", want.s_add, out_tdata[0]);
        check_field("end_added", want.e_add, out_tdata[1]);
        check_field("start_dropped", want.s_drop, out_tdata[2]);
        check_field("end_dropped", want.e_drop, out_tdata[3]);
        check_field("start_fill", want.s_fill, out_tdata[10:4]);
        check_field("end_fill", want.e_fill, out_tdata[17:11]);
        check_field("start_site_out", want.s_site, out_tdata[48:18]);
        check_field("end_site_out", want.e_site, out_tdata[79:49]);
        check_field("start_site_valid", want.s_val, out_tdata[80]);
        check_field("end_site_valid", want.e_val, out_tdata[81]);
        start_adds += want.s_add;
        end_adds += want.e_add;
        start_drops += want.s_drop;
        end_drops += want.e_drop;
        read_hits += want.s_val | want.e_val;
      end
    end
    // long hold-off while commands are still queued, so the input backs up
    if (hold_left == 0 && long_holds < 2 && seen >= (long_holds + 1) * 500 &&
        site_cmds.size() > 16) begin
      hold_left = 400;
      long_holds++;
    end
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_tick % 3 != 0);
      endcase
    end
    out_tready <= rdy;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tolerant_site_dedup_unit test failed");
      $finish;
    end
  end

  // stimulus phases
  int          phase_tol [12];
  int          phase_clear [12] = '{0, 0, 3, 8, 0, 2, 0, 5, 0, 10, 2, 0};

  initial begin
    phase_tol = '{0, 65535, 1, 5, $urandom_range(0, 65535), 100, 65535, 0,
                  $urandom_range(0, 65535), 2, $urandom_range(0, 300), tsd_pkg::TOL_RESET};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset tolerance: empty reads, unused command, boundary distances
    push_cmd(tsd_pkg::CMD_READ, 0, 0, 0);
    push_cmd(tsd_pkg::CMD_READ, 0, 0, 63);
    push_cmd(CMD_UNUSED, 0, 0, 0);
    push_cmd(tsd_pkg::CMD_ADD, 0, POS_MAX, 0);
    push_cmd(tsd_pkg::CMD_ADD, 5, POS_MAX - 5, 0);
    push_cmd(tsd_pkg::CMD_ADD, 6, POS_MAX - 6, 0);
    push_cmd(tsd_pkg::CMD_ADD, POS_MAX, 0, 0);
    push_cmd(tsd_pkg::CMD_READ, 0, 0, 0);
    push_cmd(tsd_pkg::CMD_READ, 0, 0, 2);
    push_cmd(tsd_pkg::CMD_READ, 0, 0, 63);
    push_cmd(CMD_UNUSED, POS_MAX, POS_MAX, 63);
    push_cmd(tsd_pkg::CMD_CLEAR, POS_MAX, POS_MAX, 63);
    push_cmd(tsd_pkg::CMD_READ, 0, 0, 0);
    push_cmd(tsd_pkg::CMD_ADD, 12345, 12345, 0);
    // zero tolerance: exact duplicate only
    write_tolerance(0);
    push_cmd(tsd_pkg::CMD_ADD, 12345, 12345, 0);
    push_cmd(tsd_pkg::CMD_ADD, 12346, 12344, 0);
    // widest tolerance
    write_tolerance(16'hFFFF);
    push_cmd(tsd_pkg::CMD_ADD, 12346 + 65535, 12344 + 65536, 0);
    push_cmd(tsd_pkg::CMD_ADD, POS_MAX, POS_MAX - 65535, 0);
    push_cmd(tsd_pkg::CMD_READ, 0, 0, 1);
    push_cmd(tsd_pkg::CMD_CLEAR, 0, 0, 0);

    // random phases, each under its own tolerance; the drain before each
    // write also pauses the sender until every result is back
    for (int p = 0; p < 12; p++) begin
      write_tolerance(TOL_W'(phase_tol[p]));
      queue_phase(PHASE_ITEMS, phase_clear[p], phase_tol[p]);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d commands over %0d tolerance writes, %0d long receiver holds",
             sent, tol_writes, long_holds);
    $display("sites stored start/end %0d/%0d, dropped on full list %0d/%0d, reads hit %0d",
             start_adds, end_adds, start_drops, end_drops, read_hits);
    if (fails == 0)
      $display("tolerant_site_dedup_unit test passed");
    else
      $display("tolerant_site_dedup_unit test failed");
    $finish;
  end

endmodule
